@@ hdl/npcm_pkg.sv @@
// npcm_pkg: shared types and constants for the nearest palette color match block
// request and result payload structs, controller/datapath command and status structs
// no dependencies
`default_nettype none

package npcm_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 256;
    localparam int COUNT_W             = 9;
    localparam int DIST_W              = 18;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_MATCH = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] entry_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] entry_code;
        logic [7:0] entry_extra;
    } npcm_req_t;

    typedef struct packed {
        logic [7:0]        match_code;
        logic [7:0]        match_extra;
        logic [7:0]        match_index;
        logic [DIST_W-1:0] match_distance;
        logic              exact_hit;
    } npcm_rsp_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] code;
        logic [7:0] extra;
    } npcm_entry_t;

    typedef struct packed {
        logic clear_wr;
        logic load_wr;
        logic scan_init;
        logic scan_issue;
        logic empty;
    } npcm_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic exact;
    } npcm_status_t;

endpackage

`default_nettype wire

@@ hdl/npcm_ctrl.sv @@
// npcm_ctrl: controller state machine for the nearest palette color match block
// clearing pass, request handshake, scan address sequencing, entry count register
// depends on npcm_pkg
`default_nettype none

module npcm_ctrl
    import npcm_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int IW          = $clog2(TABLE_DEPTH)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               req_cmd,
    input  wire logic               cfg_we,
    input  wire logic [COUNT_W-1:0] cfg_wdata,
    input  wire npcm_status_t       status,
    output logic                    busy,
    output logic                    done,
    output npcm_cmd_t               cmd_o,
    output logic [IW-1:0]           addr
);

    localparam int LW = (IW + 1 > COUNT_W) ? IW + 1 : COUNT_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [IW-1:0]      addr_reg, addr_next;
    logic [LW-1:0]      limit_reg, limit_next;
    logic               empty_reg, empty_next;
    logic [COUNT_W-1:0] count_reg;
    logic [LW-1:0]      count_limit;
    logic               accept;
    logic               scan_last;

    assign accept      = start && (state_reg == ST_IDLE);
    assign count_limit = (LW'(count_reg) > LW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH)
                                                              : LW'(count_reg);
    assign scan_last   = empty_reg || ((LW'(addr_reg) + LW'(1)) == limit_reg);

    always_comb
    begin
        state_next       = state_reg;
        addr_next        = addr_reg;
        limit_next       = limit_reg;
        empty_next       = empty_reg;
        cmd_o            = '0;
        cmd_o.empty      = empty_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd_o.clear_wr = 1'b1;
                if (addr_reg == IW'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + IW'(1);
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_cmd == CMD_LOAD)
                    begin
                        cmd_o.load_wr = 1'b1;
                    end
                    else
                    begin
                        cmd_o.scan_init = 1'b1;
                        addr_next       = '0;
                        limit_next      = count_limit;
                        empty_next      = (count_limit == '0);
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (status.exact)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cmd_o.scan_issue = 1'b1;
                    if (scan_last)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        addr_next = addr_reg + IW'(1);
                    end
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            addr_reg  <= '0;
            limit_reg <= '0;
            empty_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            limit_reg <= limit_next;
            empty_reg <= empty_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);
    assign addr = addr_reg;

    a_done_single : assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    a_match_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_cmd == CMD_MATCH) |=> busy)
        else $error("match request did not start a scan");

    a_done_drained : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !status.pipe_busy)
        else $error("result strobed with reads still in flight");

    a_no_issue_after_hit : assert property (@(posedge clk) disable iff (!rst_n)
        status.exact && !cmd_o.scan_init |-> !cmd_o.scan_issue)
        else $error("scan kept reading after an exact hit");

endmodule

`default_nettype wire

@@ hdl/npcm_dpath.sv @@
// npcm_dpath: palette memory, distance pipeline and best-entry tracking
// read register, squared difference stage, sum and compare stage
// depends on npcm_pkg
`default_nettype none

module npcm_dpath
    import npcm_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int IW          = $clog2(TABLE_DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire npcm_req_t     req,
    input  wire npcm_cmd_t     cmd_i,
    input  wire logic [IW-1:0] addr,
    output npcm_status_t       status,
    output npcm_rsp_t          rsp
);

    localparam int XW = ((IW > 8) ? IW : 8) + 1;

    npcm_entry_t mem [TABLE_DEPTH];

    logic [XW-1:0] idx_x;
    logic          idx_ok;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    npcm_entry_t   mem_wdata;

    npcm_entry_t   rd_reg;
    logic [IW-1:0] a1_reg, a2_reg;
    logic          v1_reg, v2_reg;
    logic [7:0]    qr_reg, qg_reg, qb_reg;
    logic [15:0]   sr_reg, sg_reg, sb_reg;
    logic [7:0]    code2_reg, extra2_reg;

    logic [7:0]    dr, dg, db;
    logic [DIST_W-1:0] dsum;

    logic              found_reg;
    logic [DIST_W-1:0] best_dist_reg;
    logic [IW-1:0]     best_idx_reg;
    logic [7:0]        best_code_reg, best_extra_reg;
    logic              exact;

    assign idx_x     = XW'(req.entry_index);
    assign idx_ok    = idx_x < XW'(TABLE_DEPTH);
    assign mem_we    = cmd_i.clear_wr || (cmd_i.load_wr && idx_ok);
    assign mem_waddr = cmd_i.clear_wr ? addr : idx_x[IW-1:0];
    assign mem_wdata = cmd_i.clear_wr ? '0
                     : {req.red, req.green, req.blue, req.entry_code, req.entry_extra};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd_i.scan_issue)
        begin
            rd_reg <= mem[addr];
        end
    end

    assign dr = (qr_reg > rd_reg.red)   ? qr_reg - rd_reg.red   : rd_reg.red   - qr_reg;
    assign dg = (qg_reg > rd_reg.green) ? qg_reg - rd_reg.green : rd_reg.green - qg_reg;
    assign db = (qb_reg > rd_reg.blue)  ? qb_reg - rd_reg.blue  : rd_reg.blue  - qb_reg;

    always_ff @(posedge clk)
    begin
        if (cmd_i.scan_init)
        begin
            qr_reg <= req.red;
            qg_reg <= req.green;
            qb_reg <= req.blue;
        end
        if (cmd_i.scan_issue)
        begin
            a1_reg <= addr;
        end
        if (v1_reg)
        begin
            sr_reg     <= 16'(dr) * 16'(dr);
            sg_reg     <= 16'(dg) * 16'(dg);
            sb_reg     <= 16'(db) * 16'(db);
            a2_reg     <= a1_reg;
            code2_reg  <= rd_reg.code;
            extra2_reg <= rd_reg.extra;
        end
    end

    assign dsum  = DIST_W'(sr_reg) + DIST_W'(sg_reg) + DIST_W'(sb_reg);
    assign exact = found_reg && (best_dist_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            found_reg      <= 1'b0;
            best_dist_reg  <= '0;
            best_idx_reg   <= '0;
            best_code_reg  <= '0;
            best_extra_reg <= '0;
        end
        else
        begin
            v1_reg <= cmd_i.scan_issue;
            v2_reg <= v1_reg;
            if (cmd_i.scan_init)
            begin
                found_reg     <= 1'b0;
                best_dist_reg <= '0;
                best_idx_reg  <= '0;
            end
            else if (v2_reg && !exact)
            begin
                if (cmd_i.empty)
                begin
                    best_code_reg  <= code2_reg;
                    best_extra_reg <= extra2_reg;
                end
                else if (!found_reg || (dsum < best_dist_reg))
                begin
                    found_reg      <= 1'b1;
                    best_dist_reg  <= dsum;
                    best_idx_reg   <= a2_reg;
                    best_code_reg  <= code2_reg;
                    best_extra_reg <= extra2_reg;
                end
            end
        end
    end

    assign status.pipe_busy = v1_reg || v2_reg;
    assign status.exact     = exact;

    assign rsp.match_code     = best_code_reg;
    assign rsp.match_extra    = best_extra_reg;
    assign rsp.match_index    = 8'(best_idx_reg);
    assign rsp.match_distance = best_dist_reg;
    assign rsp.exact_hit      = exact;

endmodule

`default_nettype wire

@@ hdl/nearest_palette_color_match.sv @@
// nearest_palette_color_match: top level of the nearest palette color match block
// joins the controller (npcm_ctrl) and the datapath (npcm_dpath)
// depends on npcm_pkg
//
// usage
// - a request is taken at a rising edge with start high and busy low
// - req.cmd load: writes one palette entry in that edge, no result, busy stays low
// - req.cmd match: scans entries 0 to n-1, one memory read per cycle
// - done rises after the last read has passed the pipeline, n the entries read;
//   n is min(entry_count, TABLE_DEPTH), 1 for an empty palette; on an exact hit the
//   scan stops with at most two reads past the hit; each read passes the read,
//   square and compare pipeline stages before done
// - busy stays high until the cycle after the strobe, so one match is at work at a time
// - done is high for exactly one cycle; the result stays on rsp until the next match
//   is taken; the receiver cannot stall it
// - cfg_we/cfg_wdata write entry_count; write only while busy is low
// - after reset the palette is cleared to zero, one entry a cycle, with busy high;
//   entry_count resets to 0
`default_nettype none

module nearest_palette_color_match
    import npcm_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire npcm_req_t          req,
    output logic                    done,
    output npcm_rsp_t               rsp,
    input  wire logic               cfg_we,
    input  wire logic [COUNT_W-1:0] cfg_wdata
);

    localparam int IW = $clog2(TABLE_DEPTH);

    npcm_cmd_t     cmd;
    npcm_status_t  status;
    logic [IW-1:0] addr;

    npcm_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IW          (IW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req_cmd   (req.cmd),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .status    (status),
        .busy      (busy),
        .done      (done),
        .cmd_o     (cmd),
        .addr      (addr)
    );

    npcm_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IW          (IW)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd_i  (cmd),
        .addr   (addr),
        .status (status),
        .rsp    (rsp)
    );

endmodule

`default_nettype wire
